// File: src/chd_pkg.sv
// Shared types and constants for the chunk header deframer.
package chd_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int FIELD_W          = 32;
  localparam int BYTE_W           = 8;
  localparam int TDATA_W          = 3 * FIELD_W + BYTE_W;
  localparam int TUSER_W          = 4;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] command;
    logic [FIELD_W-1:0] error;
    logic               chunk_kind;
    logic [FIELD_W-1:0] size;
    logic [BYTE_W-1:0]  payload;
    logic               last;
    logic               empty;
  } chd_result_t;

endpackage

// File: src/chunk_header_deframer_top.sv
// Chunk header deframer: top level with input register, parser and result register.
//
// Takes one byte per transfer from a stream of chunks command:error:type:size:payload
// and emits one header result per chunk, one result per payload byte (tlast on the
// final one) and an error result on malformed headers, after which parsing restarts.
// Digit bytes and separators give no result, but for the colon that ends the size
// field, which gives the header result. One byte is taken every cycle while
// out_tready stays high; a result left waiting in the result register holds off the
// input. A result is presented once its byte has passed the input register: the byte
// sits there until the combinational parse logic loads the result register. Numbers
// saturate at the NUMBER_WIDTH maximum and are shown as their low 32 bits.
module chunk_header_deframer_top
  import chd_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [BYTE_W-1:0]  in_tdata,   // [7:0] in_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [31:0] command_number, [63:32] error_code,
                                         // [95:64] chunk_size, [103:96] payload_byte
  output logic [TUSER_W-1:0] out_tuser,  // [1:0] result_kind, [2] chunk_kind,
                                         // [3] empty_chunk
  output logic               out_tlast   // last_payload
);

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              can_load;
  logic              step;
  logic              res_valid;
  chd_result_t       res;

  assign step      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  chd_parser #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (step),
    .byte_i     (in_byte_r),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  chd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (step && res_valid),
    .res_i     (res),
    .can_load_o(can_load),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// File: src/chd_parser.sv
// Header parse state machine: digit accumulation, separators, payload count.
module chd_parser
  import chd_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              res_valid_o,
  output chd_result_t       res_o
);

  localparam logic [2:0] PH_CMD     = 3'd0;
  localparam logic [2:0] PH_ERR     = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_TCOLON  = 3'd3;
  localparam logic [2:0] PH_SIZE    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  localparam int EXT_W = NUMBER_WIDTH + 4;

  logic [2:0]              phase_r, phase_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic                    seen_r, seen_nxt;
  logic [NUMBER_WIDTH-1:0] cmd_r, cmd_nxt;
  logic [NUMBER_WIDTH-1:0] err_r, err_nxt;
  logic                    ckind_r, ckind_nxt;
  logic [NUMBER_WIDTH-1:0] remain_r, remain_nxt;

  logic [3:0]              digit;
  logic [EXT_W-1:0]        acc_ext;
  logic [EXT_W-1:0]        acc_sum;
  logic [NUMBER_WIDTH-1:0] acc_step;
  logic [NUMBER_WIDTH-1:0] remain_dec;
  logic                    is_digit;

  assign digit      = 4'(byte_i - CH_ZERO);
  assign acc_ext    = EXT_W'(acc_r);
  assign acc_sum    = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(digit);
  assign acc_step   = (acc_sum[EXT_W-1:NUMBER_WIDTH] != 4'd0) ? '1
                                                               : acc_sum[NUMBER_WIDTH-1:0];
  assign remain_dec = remain_r - NUMBER_WIDTH'(1);
  assign is_digit   = byte_i inside {[CH_ZERO:CH_NINE]};

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    cmd_nxt     = cmd_r;
    err_nxt     = err_r;
    ckind_nxt   = ckind_r;
    remain_nxt  = remain_r;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_ERROR;

    case (phase_r)
      PH_PAYLOAD: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_PAYLOAD;
        res_o.command    = FIELD_W'(cmd_r);
        res_o.error      = FIELD_W'(err_r);
        res_o.chunk_kind = ckind_r;
        res_o.size       = FIELD_W'(acc_r);
        res_o.payload    = byte_i;
        res_o.last       = (remain_dec == '0);
        remain_nxt       = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt  = PH_CMD;
          acc_nxt    = '0;
          seen_nxt   = 1'b0;
        end
      end
      PH_TYPE: begin
        if (byte_i == CH_M || byte_i == CH_L) begin
          ckind_nxt = (byte_i == CH_L);
          phase_nxt = PH_TCOLON;
        end else begin
          res_valid_o = 1'b1;
        end
      end
      PH_TCOLON: begin
        if (byte_i == CH_COLON) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
        end else begin
          res_valid_o = 1'b1;
        end
      end
      PH_CMD, PH_ERR, PH_SIZE: begin
        if (is_digit) begin
          acc_nxt  = acc_step;
          seen_nxt = 1'b1;
        end else if (byte_i != CH_COLON || !seen_r) begin
          res_valid_o = 1'b1;
        end else begin
          seen_nxt = 1'b0;
          if (phase_r == PH_CMD) begin
            cmd_nxt   = acc_r;
            acc_nxt   = '0;
            phase_nxt = PH_ERR;
          end else if (phase_r == PH_ERR) begin
            err_nxt   = acc_r;
            acc_nxt   = '0;
            phase_nxt = PH_TYPE;
          end else begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_HEADER;
            res_o.command    = FIELD_W'(cmd_r);
            res_o.error      = FIELD_W'(err_r);
            res_o.chunk_kind = ckind_r;
            res_o.size       = FIELD_W'(acc_r);
            if (acc_r == '0) begin
              res_o.empty = 1'b1;
              phase_nxt   = PH_CMD;
              remain_nxt  = '0;
            end else begin
              remain_nxt  = acc_r;
              phase_nxt   = PH_PAYLOAD;
            end
          end
        end
      end
      default: begin
        res_valid_o = 1'b1;
      end
    endcase

    // any error restarts at a new header
    if (res_valid_o && res_o.kind == KIND_ERROR) begin
      phase_nxt  = PH_CMD;
      acc_nxt    = '0;
      seen_nxt   = 1'b0;
      remain_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      cmd_r    <= '0;
      err_r    <= '0;
      ckind_r  <= 1'b0;
      remain_r <= '0;
    end else if (step_i) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      cmd_r    <= cmd_nxt;
      err_r    <= err_nxt;
      ckind_r  <= ckind_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

// File: src/chd_out_reg.sv
// Result register with stream handshake toward the consumer.
module chd_out_reg
  import chd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_i,
  input  chd_result_t        res_i,
  output logic               can_load_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0] out_tuser,
  output logic               out_tlast
);

  logic        valid_r, valid_nxt;
  chd_result_t res_r;

  assign can_load_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.payload, res_r.size, res_r.error, res_r.command};
  assign out_tuser  = {res_r.empty, res_r.chunk_kind, res_r.kind};
  assign out_tlast  = res_r.last;

endmodule

// File: sim/tb_chunk_header_deframer_top.sv
// Self-checking testbench for chunk_header_deframer_top: directed table plus random chunk streams.
`timescale 1ns / 1ps

module tb_chunk_header_deframer_top;
  import chd_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DIRECTED_N   = 28;
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [7:0] CH_BREAK = "x";

  localparam chd_result_t NO_RESULT    = '0;
  localparam chd_result_t FAULT_RESULT = {KIND_ERROR, 107'd0};
  localparam chd_result_t EMPTY_LAST   = {KIND_HEADER, 32'd0, 32'd0, 1'b1, 32'd0, 8'd0,
                                          1'b0, 1'b1};

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    chd_result_t want;
  } row_t;

  typedef enum logic [2:0] {
    AT_COMMAND,
    AT_ERROR,
    AT_TYPE,
    AT_TYPE_COLON,
    AT_SIZE,
    AT_PAYLOAD
  } parse_phase_e;

  // directed bytes; typed rows carry an expectation readable at a glance
  localparam row_t DIRECTED_ROWS [DIRECTED_N] = '{
    {CH_COLON, 1'b1, FAULT_RESULT},
    {"9",      1'b0, NO_RESULT},
    {"q",      1'b1, FAULT_RESULT},
    {"0",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {"0",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {CH_L,     1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {"0",      1'b0, NO_RESULT},
    {CH_COLON, 1'b1, EMPTY_LAST},
    {"1",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {CH_COLON, 1'b1, FAULT_RESULT},
    {"3",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {"4",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {CH_BREAK, 1'b1, FAULT_RESULT},
    {"2",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {"0",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {CH_M,     1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {"1",      1'b0, NO_RESULT},
    {CH_COLON, 1'b0, NO_RESULT},
    {8'hff,    1'b0, NO_RESULT}
  };

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [BYTE_W-1:0]  in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;
  logic               out_tlast;

  logic        calm        = 1'b0;
  int          stall_left  = 0;
  int          cycle_count = 0;
  int          taken       = 0;
  int          errors      = 0;
  row_t        feed[$];
  logic [7:0]  head_bytes[$];
  chd_result_t pending_results[$];

  parse_phase_e at_phase    = AT_COMMAND;
  logic [31:0]  digits_acc  = '0;
  logic         have_digit  = 1'b0;
  logic [31:0]  cur_command = '0;
  logic [31:0]  cur_error   = '0;
  logic         cur_kind    = 1'b0;
  logic [31:0]  left_bytes  = '0;

  chunk_header_deframer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void restart_parse();
    at_phase   = AT_COMMAND;
    digits_acc = '0;
    have_digit = 1'b0;
    left_bytes = '0;
  endfunction

  function automatic bit flag_fault(output chd_result_t r);
    restart_parse();
    r = FAULT_RESULT;
    return 1'b1;
  endfunction

  // advances the parse state by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, output chd_result_t r);
    logic [63:0] grown;
    r = NO_RESULT;
    case (at_phase)
      AT_PAYLOAD: begin
        left_bytes   = left_bytes - 32'd1;
        r.kind       = KIND_PAYLOAD;
        r.command    = cur_command;
        r.error      = cur_error;
        r.chunk_kind = cur_kind;
        r.size       = digits_acc;
        r.payload    = b;
        r.last       = (left_bytes == 0);
        if (r.last) restart_parse();
        return 1'b1;
      end
      AT_TYPE: begin
        if (b == CH_M) cur_kind = 1'b0;
        else if (b == CH_L) cur_kind = 1'b1;
        else return flag_fault(r);
        at_phase = AT_TYPE_COLON;
        return 1'b0;
      end
      AT_TYPE_COLON: begin
        if (b != CH_COLON) return flag_fault(r);
        at_phase   = AT_SIZE;
        digits_acc = '0;
        have_digit = 1'b0;
        return 1'b0;
      end
      default: ;
    endcase
    if (b >= CH_ZERO && b <= CH_NINE) begin
      grown      = {32'd0, digits_acc} * 64'd10 + 64'(b - CH_ZERO);
      digits_acc = (grown > 64'hffff_ffff) ? '1 : grown[31:0];
      have_digit = 1'b1;
      return 1'b0;
    end
    if (b != CH_COLON || !have_digit) return flag_fault(r);
    have_digit = 1'b0;
    case (at_phase)
      AT_COMMAND: begin
        cur_command = digits_acc;
        digits_acc  = '0;
        at_phase    = AT_ERROR;
        return 1'b0;
      end
      AT_ERROR: begin
        cur_error  = digits_acc;
        digits_acc = '0;
        at_phase   = AT_TYPE;
        return 1'b0;
      end
      default: ;
    endcase
    r.kind       = KIND_HEADER;
    r.command    = cur_command;
    r.error      = cur_error;
    r.chunk_kind = cur_kind;
    r.size       = digits_acc;
    if (digits_acc == 0) begin
      r.empty = 1'b1;
      restart_parse();
    end else begin
      left_bytes = digits_acc;
      at_phase   = AT_PAYLOAD;
    end
    return 1'b1;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    feed.push_back({b, 1'b0, NO_RESULT});
  endfunction

  function automatic logic [63:0] pick_number();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return 64'hffff_ffff;
      2:       return 64'd4294967296;
      3:       return 64'd99999999999999;
      4, 5:    return 64'($urandom);
      default: return 64'($urandom_range(0, 999));
    endcase
  endfunction

  function automatic void add_field(input logic [63:0] v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) head_bytes.push_back(CH_ZERO);
    for (int k = 0; k < digits.len(); k++) head_bytes.push_back(digits[k]);
    head_bytes.push_back(CH_COLON);
  endfunction

  // one chunk, now and then corrupted or preceded by line noise;
  // trailing break bytes force the parser back to a header start
  function automatic void add_chunk();
    logic [31:0] size;
    logic [7:0]  junk;
    int          pos;
    bit          broken;
    head_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      add_byte(CH_BREAK);
    end
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    add_field(pick_number());
    add_field(pick_number());
    head_bytes.push_back($urandom_range(0, 1) ? CH_L : CH_M);
    head_bytes.push_back(CH_COLON);
    add_field(64'(size));
    broken = ($urandom_range(0, 6) == 0);
    if (broken) begin
      pos  = $urandom_range(0, head_bytes.size() - 1);
      junk = 8'($urandom_range(0, 255));
      if (junk >= CH_ZERO && junk <= CH_NINE) junk = junk ^ 8'h40;
      case ($urandom_range(0, 2))
        0:       head_bytes[pos] = junk;
        1:       head_bytes.delete(pos);
        default: head_bytes.insert(pos, junk);
      endcase
    end
    foreach (head_bytes[k]) add_byte(head_bytes[k]);
    if (broken) repeat (size + 1) add_byte(CH_BREAK);
    else repeat (size) add_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[chunk_header_deframer_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    chd_result_t predicted;
    chd_result_t want;
    bit          produced;
    if (rst_n && in_tvalid && in_tready) begin
      produced = parse_byte(in_tdata, predicted);
      if (feed[taken].typed) pending_results.push_back(feed[taken].want);
      else if (produced) pending_results.push_back(predicted);
      taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no result expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(out_tuser[1:0]));
        check_field("command_number", want.command, out_tdata[31:0]);
        check_field("error_code", want.error, out_tdata[63:32]);
        check_field("chunk_kind", 32'(want.chunk_kind), 32'(out_tuser[2]));
        check_field("chunk_size", want.size, out_tdata[95:64]);
        check_field("payload_byte", 32'(want.payload), 32'(out_tdata[103:96]));
        check_field("last_payload", 32'(want.last), 32'(out_tlast));
        check_field("empty_chunk", 32'(want.empty), 32'(out_tuser[3]));
      end
    end
  end

  initial begin : drive
    bit quiet;
    foreach (DIRECTED_ROWS[k]) feed.push_back(DIRECTED_ROWS[k]);
    while (feed.size() < DIRECTED_N + RANDOM_ITEMS) add_chunk();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < feed.size(); i++) begin
      quiet = (i >= feed.size() - CALM_TAIL) || ((i / 200) % 3 == 2);
      calm <= quiet;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= feed[i].b;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;

    while (taken < feed.size() || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[chunk_header_deframer_top] OK");
    end else begin
      $display("[chunk_header_deframer_top] ERROR");
    end
    $finish;
  end

endmodule
